/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/qrs_pkg.sv */
// Package of widths, codes, types and helpers for the quadratic root solver.
package qrs_pkg;

    localparam int DW       = 32;            // coefficient and root width
    localparam int FW       = 16;            // fraction bits
    localparam int PW       = 2 * DW;        // magnitude product width
    localparam int RW       = PW + 2;        // discriminant magnitude width (even)
    localparam int SW       = RW / 2;        // square root width
    localparam int SQ_REM_W = SW + 2;        // square root remainder width
    localparam int NW       = SW + 2;        // signed numerator width
    localparam int MW       = NW - 1;        // numerator magnitude width
    localparam int NUMW     = MW + FW;       // dividend width, also quotient width
    localparam int DVW      = DW + 1;        // divisor width (2*|a|)
    localparam int TOL_W    = 16;
    localparam int CNT_W    = 2;
    localparam int ST_W     = 2;
    localparam int ADDR_W   = 3;
    localparam int IN_TDATA_W  = ((3 * DW + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * DW + CNT_W + ST_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_AZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

    localparam logic [ADDR_W-3:0] REG_TOL = '0;
    localparam logic [TOL_W-1:0]  TOL_RESET = 16'd7;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_ONE,
        CLS_TWO
    } t_cls;

    typedef struct packed {
        logic signed [DW-1:0] a_coef;
        logic signed [DW-1:0] b_coef;
        t_cls                 cls;
        logic                 a_zero;
    } t_sq_side;

    typedef struct packed {
        logic [RW-1:0]       rad;
        logic [SQ_REM_W-1:0] rem;
        logic [SW-1:0]       root;
        t_sq_side            side;
    } t_sq;

    typedef struct packed {
        logic [DVW-1:0] dvsr;
        logic           neg1;
        logic           neg2;
        t_cls           cls;
        logic           a_zero;
    } t_dv_side;

    typedef struct packed {
        logic [NUMW-1:0] num1;
        logic [NUMW-1:0] num2;
        logic [DVW-1:0]  rem1;
        logic [DVW-1:0]  rem2;
        logic [NUMW-1:0] q1;
        logic [NUMW-1:0] q2;
        t_dv_side        side;
    } t_dv;

    // Magnitude of a signed coefficient; the most negative value maps to 2^(DW-1).
    function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
        logic [DW-1:0] u;
        u = x;
        return x[DW-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

/* src/quadratic_root_solver.sv */
// Top level of the quadratic root solver: front end, cell rows, output register, APB port.
//
// Input channel (i_s_axis_*): one item carries a, b and c in signed Q16.16.
// Output channel (o_m_axis_*): one item per input item, in order, with the root
//   count, the ascending roots and a status code (ok, leading coefficient zero,
//   root saturated).
// APB port: register 0 at byte address 0 is disc_tolerance (16 bits, reset 7).
//   Write it only while no item is in flight. pready is tied high.
// Path from input accept to output valid: one product stage, a row
//   of 33 square root cells (one root bit each), a row of 50 divider cells (one
//   quotient bit of both roots each) and the output register.
// Throughput: one item per cycle unless stalled. Every cell holds its own valid bit
//   and takes a new item whenever it is empty or its neighbor takes its item, so the
//   rows fill any bubble and input is accepted while a result waits at the output.
// Stall: when the receiver holds i_m_axis_tready low, the result holds in the
//   output register and the cells back up one by one; input stops only when
//   every cell is full.
// Reset: synchronous, active low; clears every valid bit and restores the
//   tolerance to 7.
`include "assert_macros.svh"

module quadratic_root_solver import qrs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // a_coef [31:0], b_coef [63:32], c_coef [95:64]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // root_count [1:0], root_low [33:2], root_high [65:34], status [67:66], zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic [NUMW-1:0] Q_HALF = NUMW'(1) << (DW - 1);

    // Configuration register.
    logic [TOL_W-1:0] r_tol;

    // Product stage.
    logic                 r1_v;
    logic [PW-1:0]        r1_bb;
    logic [PW-1:0]        r1_ac;
    logic signed [DW-1:0] r1_a;
    logic signed [DW-1:0] r1_b;
    logic                 r1_add;
    logic                 r1_azero;
    logic                 w1_en;

    logic signed [DW-1:0] w_a;
    logic signed [DW-1:0] w_b;
    logic signed [DW-1:0] w_c;

    // Discriminant logic ahead of the square root row.
    logic [RW-1:0] w_bb4;
    logic [RW-1:0] w_ac4;
    logic [RW-1:0] w_dmag;
    logic [RW-1:0] w_thr;
    logic          w_dneg;
    t_cls          w_cls;
    t_sq           w_sq_in;

    t_sq  sq_d   [0:SW];
    logic sq_v   [0:SW];
    logic sq_rdy [0:SW];

    // Numerators ahead of the divider row.
    logic signed [NW-1:0] w_bext;
    logic signed [NW-1:0] w_sext;
    logic signed [NW-1:0] w_num1;
    logic signed [NW-1:0] w_num2;
    logic [MW-1:0]        w_m1;
    logic [MW-1:0]        w_m2;
    t_sq_side             w_sside;
    t_dv                  w_dv_in;

    t_dv  dv_d   [0:NUMW];
    logic dv_v   [0:NUMW];
    logic dv_rdy [0:NUMW];

    // Result assembly and output register.
    t_dv                  w_last;
    logic [DW:0]          w_sr1;
    logic [DW:0]          w_sr2;
    logic signed [DW-1:0] w_r1;
    logic signed [DW-1:0] w_r2;
    logic [CNT_W-1:0]     n_cnt;
    logic [DW-1:0]        n_lo;
    logic [DW-1:0]        n_hi;
    logic [ST_W-1:0]      n_st;
    logic                 w_out_en;

    logic                 r_out_v;
    logic [CNT_W-1:0]     r_cnt;
    logic [DW-1:0]        r_lo;
    logic [DW-1:0]        r_hi;
    logic [ST_W-1:0]      r_st;

    // Saturate a quotient magnitude to a signed root; top bit flags saturation.
    function automatic logic [DW:0] sat_root(input logic [NUMW-1:0] q, input logic neg);
        logic [DW-1:0] v;
        logic          s;
        v = q[DW-1:0];
        s = 1'b0;
        if (neg) begin
            if (q > Q_HALF) begin
                s = 1'b1;
                v = {1'b1, {(DW-1){1'b0}}};
            end else begin
                v = ~v + 1'b1;
            end
        end else if (q >= Q_HALF) begin
            s = 1'b1;
            v = {1'b0, {(DW-1){1'b1}}};
        end
        return {s, v};
    endfunction

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_TOL) ? {{(32-TOL_W){1'b0}}, r_tol} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_TOL) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    // ---------------------------------------------------------------- products
    assign w_a   = i_s_axis_tdata[DW-1:0];
    assign w_b   = i_s_axis_tdata[2*DW-1:DW];
    assign w_c   = i_s_axis_tdata[3*DW-1:2*DW];
    assign w1_en = !r1_v || sq_rdy[0];
    assign o_s_axis_tready = w1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w1_en) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w1_en) begin
            r1_bb    <= PW'(mag(w_b)) * PW'(mag(w_b));
            r1_ac    <= PW'(mag(w_a)) * PW'(mag(w_c));
            r1_a     <= w_a;
            r1_b     <= w_b;
            // Opposite signs, or c zero: 4ac adds to b*b.
            r1_add   <= !((w_a[DW-1] == w_c[DW-1]) && (w_c != '0));
            r1_azero <= (w_a == '0);
        end
    end

    // ---------------------------------------------------------------- discriminant
    always_comb begin
        w_bb4 = {2'b00, r1_bb};
        w_ac4 = {r1_ac, 2'b00};
        w_thr = RW'({r_tol, {FW{1'b0}}});
        if (r1_add) begin
            w_dmag = w_bb4 + w_ac4;
            w_dneg = 1'b0;
        end else if (w_bb4 >= w_ac4) begin
            w_dmag = w_bb4 - w_ac4;
            w_dneg = 1'b0;
        end else begin
            w_dmag = w_ac4 - w_bb4;
            w_dneg = 1'b1;
        end
        if (w_dmag > w_thr) begin
            w_cls = w_dneg ? CLS_NONE : CLS_TWO;
        end else begin
            w_cls = CLS_ONE;
        end
        // Feed zero for the double root so both lanes divide -b alone.
        w_sq_in.rad         = (w_cls == CLS_TWO) ? w_dmag : '0;
        w_sq_in.rem         = '0;
        w_sq_in.root        = '0;
        w_sq_in.side.a_coef = r1_a;
        w_sq_in.side.b_coef = r1_b;
        w_sq_in.side.cls    = w_cls;
        w_sq_in.side.a_zero = r1_azero;
    end

    assign sq_v[0] = r1_v;
    assign sq_d[0] = w_sq_in;

    for (genvar k = 0; k < SW; k++) begin : g_sq
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[k]),
            .i_data  (sq_d[k]),
            .o_ready (sq_rdy[k]),
            .o_valid (sq_v[k+1]),
            .o_data  (sq_d[k+1]),
            .i_ready (sq_rdy[k+1])
        );
    end

    assign sq_rdy[SW] = dv_rdy[0];

    // ---------------------------------------------------------------- numerators
    always_comb begin
        w_sside = sq_d[SW].side;
        w_bext  = NW'(w_sside.b_coef);
        w_sext  = {2'b00, sq_d[SW].root};
        w_num1  = w_sext - w_bext;
        w_num2  = -w_bext - w_sext;
        w_m1    = w_num1[NW-1] ? MW'(-w_num1) : w_num1[MW-1:0];
        w_m2    = w_num2[NW-1] ? MW'(-w_num2) : w_num2[MW-1:0];
        w_dv_in.num1        = {w_m1, {FW{1'b0}}};
        w_dv_in.num2        = {w_m2, {FW{1'b0}}};
        w_dv_in.rem1        = '0;
        w_dv_in.rem2        = '0;
        w_dv_in.q1          = '0;
        w_dv_in.q2          = '0;
        w_dv_in.side.dvsr   = {mag(w_sside.a_coef), 1'b0};
        w_dv_in.side.neg1   = w_num1[NW-1] ^ w_sside.a_coef[DW-1];
        w_dv_in.side.neg2   = w_num2[NW-1] ^ w_sside.a_coef[DW-1];
        w_dv_in.side.cls    = w_sside.cls;
        w_dv_in.side.a_zero = w_sside.a_zero;
    end

    assign dv_v[0] = sq_v[SW];
    assign dv_d[0] = w_dv_in;

    for (genvar k = 0; k < NUMW; k++) begin : g_dv
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[k]),
            .i_data  (dv_d[k]),
            .o_ready (dv_rdy[k]),
            .o_valid (dv_v[k+1]),
            .o_data  (dv_d[k+1]),
            .i_ready (dv_rdy[k+1])
        );
    end

    assign w_out_en     = !r_out_v || i_m_axis_tready;
    assign dv_rdy[NUMW] = w_out_en;

    // ---------------------------------------------------------------- results
    always_comb begin
        w_last = dv_d[NUMW];
        w_sr1  = sat_root(w_last.q1, w_last.side.neg1);
        w_sr2  = sat_root(w_last.q2, w_last.side.neg2);
        w_r1   = w_sr1[DW-1:0];
        w_r2   = w_sr2[DW-1:0];
        n_cnt  = CNT_NONE;
        n_lo   = '0;
        n_hi   = '0;
        n_st   = ST_OK;
        if (w_last.side.a_zero) begin
            n_st = ST_AZERO;
        end else begin
            case (w_last.side.cls)
                CLS_TWO: begin
                    n_cnt = CNT_TWO;
                    // Sort after saturation.
                    n_lo  = (w_r1 > w_r2) ? w_r2 : w_r1;
                    n_hi  = (w_r1 > w_r2) ? w_r1 : w_r2;
                    n_st  = (w_sr1[DW] || w_sr2[DW]) ? ST_SAT : ST_OK;
                end
                CLS_ONE: begin
                    n_cnt = CNT_ONE;
                    n_lo  = w_r1;
                    n_hi  = w_r1;
                    n_st  = w_sr1[DW] ? ST_SAT : ST_OK;
                end
                default: begin
                    n_cnt = CNT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_en) begin
            r_out_v <= dv_v[NUMW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_cnt <= n_cnt;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_st  <= n_st;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, r_st, r_hi, r_lo, r_cnt};

    // ---------------------------------------------------------------- checks
    `ASSERT_IMPL(a_sorted, i_clk, i_rst_n, r_out_v && r_cnt == CNT_TWO, $signed(r_lo) <= $signed(r_hi))
    `ASSERT_IMPL(a_double, i_clk, i_rst_n, r_out_v && r_cnt == CNT_ONE, r_lo == r_hi)
    `ASSERT_IMPL(a_azero, i_clk, i_rst_n, r_out_v && r_st == ST_AZERO, r_cnt == CNT_NONE && r_lo == '0 && r_hi == '0)
    `ASSERT_NEXT(a_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r1_v)

endmodule

/* src/qrs_sqrt_cell.sv */
// One cell of the square root row: settles one root bit per cycle unless it is full and its neighbor stalls.
module qrs_sqrt_cell import qrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sq  i_data,
    output logic o_ready,
    output logic o_valid,
    output t_sq  o_data,
    input  logic i_ready
);

    logic                r_valid;
    t_sq                 r_data;
    t_sq                 n_data;
    logic                w_en;
    logic [SQ_REM_W+1:0] w_cat;
    logic [SQ_REM_W+1:0] w_trial;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data     = i_data;
        w_cat      = {i_data.rem, i_data.rad[RW-1 -: 2]};
        w_trial    = {{(SQ_REM_W-SW){1'b0}}, i_data.root, 2'b01};
        n_data.rad = {i_data.rad[RW-3:0], 2'b00};
        if (w_cat >= w_trial) begin
            n_data.rem  = SQ_REM_W'(w_cat - w_trial);
            n_data.root = {i_data.root[SW-2:0], 1'b1};
        end else begin
            n_data.rem  = w_cat[SQ_REM_W-1:0];
            n_data.root = {i_data.root[SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data <= n_data;
        end
    end

endmodule

/* src/qrs_div_cell.sv */
// Divider row cell: one quotient bit of both roots per cycle unless stalled.
module qrs_div_cell import qrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_dv  i_data,
    output logic o_ready,
    output logic o_valid,
    output t_dv  o_data,
    input  logic i_ready
);

    logic         r_valid;
    t_dv          r_data;
    t_dv          n_data;
    logic         w_en;
    logic [DVW:0] w_cat1;
    logic [DVW:0] w_cat2;
    logic [DVW:0] w_dsv;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data      = i_data;
        w_dsv       = {1'b0, i_data.side.dvsr};
        w_cat1      = {i_data.rem1, i_data.num1[NUMW-1]};
        w_cat2      = {i_data.rem2, i_data.num2[NUMW-1]};
        n_data.num1 = {i_data.num1[NUMW-2:0], 1'b0};
        n_data.num2 = {i_data.num2[NUMW-2:0], 1'b0};
        if (w_cat1 >= w_dsv) begin
            n_data.rem1 = DVW'(w_cat1 - w_dsv);
            n_data.q1   = {i_data.q1[NUMW-2:0], 1'b1};
        end else begin
            n_data.rem1 = w_cat1[DVW-1:0];
            n_data.q1   = {i_data.q1[NUMW-2:0], 1'b0};
        end
        if (w_cat2 >= w_dsv) begin
            n_data.rem2 = DVW'(w_cat2 - w_dsv);
            n_data.q2   = {i_data.q2[NUMW-2:0], 1'b1};
        end else begin
            n_data.rem2 = w_cat2[DVW-1:0];
            n_data.q2   = {i_data.q2[NUMW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data <= n_data;
        end
    end

endmodule
